[rtl/dns_name_lru_cache_macros.svh]
// Assertion macros used by the DNS name cache RTL.
`ifndef DNS_NAME_LRU_CACHE_MACROS_SVH
`define DNS_NAME_LRU_CACHE_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define DNSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define DNSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/dnsc_pkg.sv]
// Shared field widths for the DNS name cache.
`default_nettype none
package dnsc_pkg;
  localparam int unsigned CharW = 8;
  localparam int unsigned AddrW = 32;

  typedef enum logic {
    FUNC_QUERY  = 1'b0,
    FUNC_INSERT = 1'b1
  } func_e;
endpackage
`default_nettype wire

[rtl/dnsc_if.sv]
// Request and response channel interfaces of the DNS name cache.
`default_nettype none
interface dnsc_req_if;
  import dnsc_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [CharW-1:0] name_char;
  logic             name_last;
  logic [AddrW-1:0] ip_addr;
  modport source (output valid, func, name_char, name_last, ip_addr, input ready);
  modport sink   (input valid, func, name_char, name_last, ip_addr, output ready);
endinterface

interface dnsc_rsp_if;
  import dnsc_pkg::*;
  logic             valid;
  logic             ready;
  logic             hit;
  logic [AddrW-1:0] ip_out;
  logic             evicted;
  modport source (output valid, hit, ip_out, evicted, input ready);
  modport sink   (input valid, hit, ip_out, evicted, output ready);
endinterface
`default_nettype wire

[rtl/dns_name_lru_cache.sv]
// Fully associative LRU cache mapping streamed domain names to IPv4 addresses.
//
// Usage: a name enters on req_i one character per request, name_last on its
// final character; func and ip_addr count only on that last character.
// Each character is compared in the same cycle against every cached name:
// each slot has its own name memory, read one character ahead so the read
// data is waiting in a register when the request arrives.
// A request carrying name_last produces one response on rsp_o (hit, address
// on a query hit, eviction flag); other requests produce none.
// Latency: the response is valid the cycle after the last character is taken.
// Throughput: one request per cycle while the receiver keeps up.
// A stalled response holds in the output register and req_i.ready drops
// until it is taken.
// Reset clears the recency list, entry count and match progress at once;
// name and address storage need no clearing pass.
`default_nettype none
module dns_name_lru_cache #(
  parameter int unsigned CACHE_ENTRIES = 16,
  parameter int unsigned NAME_BYTES    = 256
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  dnsc_req_if.sink      req_i,
  dnsc_rsp_if.source    rsp_o
);
  import dnsc_pkg::*;
  `include "dns_name_lru_cache_macros.svh"

  localparam int unsigned Slots = CACHE_ENTRIES + 1;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned IdxW  = (NAME_BYTES > 2) ? $clog2(NAME_BYTES) : 1;
  localparam int unsigned CiW   = $clog2(NAME_BYTES + 1);
  localparam int unsigned CntW  = $clog2(CACHE_ENTRIES + 1);
  localparam int unsigned RankW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [CiW-1:0]   MaxLen = CiW'(NAME_BYTES - 1);
  localparam logic [CntW-1:0]  Full   = CntW'(CACHE_ENTRIES);

  // State
  logic [SlotW-1:0] sor_q [CACHE_ENTRIES];
  logic [SlotW-1:0] sor_d [CACHE_ENTRIES];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CiW-1:0]   ci_q, ci_d;
  logic [Slots-1:0] match_q, match_d;
  logic [SlotW-1:0] spare_q, spare_d;
  logic [IdxW-1:0]  len_q  [Slots];
  logic [AddrW-1:0] addr_q [Slots];
  logic [CharW-1:0] rd_q   [Slots];

  logic             out_valid_q, out_hit_q, out_ev_q;
  logic [AddrW-1:0] out_ip_q;

  logic             acc, wr_en;
  logic [CiW-1:0]   ci_next;
  logic [IdxW-1:0]  wr_idx, rd_idx;
  logic [Slots-1:0] len_ok;
  logic [CACHE_ENTRIES-1:0] rank_hit;
  logic             found;
  logic [RankW-1:0] hit_rank;
  logic [SlotW-1:0] hit_slot;
  logic             full;
  logic [CntW-1:0]  cnt_ins;
  logic [Slots-1:0] used;
  logic [SlotW-1:0] free_slot;
  logic             do_ins, do_upd, ev;

  assign acc           = req_i.valid && req_i.ready;
  assign req_i.ready   = !out_valid_q || rsp_o.ready;
  assign ci_next       = (ci_q < MaxLen) ? ci_q + CiW'(1) : CiW'(NAME_BYTES);
  assign wr_en         = acc && (ci_q < MaxLen);
  assign wr_idx        = ci_q[IdxW-1:0];
  assign rd_idx        = ci_d[IdxW-1:0];

  // Per-slot name memories, read one character ahead with write bypass
  for (genvar s = 0; s < Slots; s++) begin : g_slot
    logic [CharW-1:0] mem [NAME_BYTES];
    always_ff @(posedge clk_i) begin
      if (wr_en && spare_q == SlotW'(s)) begin
        mem[wr_idx] <= req_i.name_char;
      end
      if (wr_en && spare_q == SlotW'(s) && wr_idx == rd_idx) begin
        rd_q[s] <= req_i.name_char;
      end else begin
        rd_q[s] <= mem[rd_idx];
      end
    end
  end

  // Update per-slot match flags and length checks
  always_comb begin
    for (int s = 0; s < Slots; s++) begin
      match_d[s] = match_q[s] && (ci_q < MaxLen) && (ci_q < CiW'(len_q[s]))
                   && (rd_q[s] == req_i.name_char);
      len_ok[s]  = (CiW'(len_q[s]) == ci_next);
    end
  end

  // Pick the most recent matching entry
  always_comb begin
    for (int r = 0; r < CACHE_ENTRIES; r++) begin
      rank_hit[r] = (CntW'(r) < cnt_q) && match_d[sor_q[r]] && len_ok[sor_q[r]];
    end
    found    = 1'b0;
    hit_rank = '0;
    for (int r = CACHE_ENTRIES - 1; r >= 0; r--) begin
      if (rank_hit[r]) begin
        found    = 1'b1;
        hit_rank = RankW'(r);
      end
    end
    hit_slot = sor_q[hit_rank];
  end

  // Work out the next free slot after an insert below capacity
  always_comb begin
    full    = (cnt_q >= Full);
    cnt_ins = full ? Full : cnt_q + CntW'(1);
    used    = '0;
    for (int s = 0; s < Slots; s++) begin
      if (spare_q == SlotW'(s)) used[s] = 1'b1;
      for (int r = 0; r + 1 < CACHE_ENTRIES; r++) begin
        if (CntW'(r + 1) < cnt_ins && sor_q[r] == SlotW'(s)) used[s] = 1'b1;
      end
    end
    free_slot = '0;
    for (int s = Slots - 1; s >= 0; s--) begin
      if (!used[s]) free_slot = SlotW'(s);
    end
  end

  // Next state of the recency list and counters
  always_comb begin
    do_upd  = acc && req_i.name_last && found;
    do_ins  = acc && req_i.name_last && !found && (req_i.func == FUNC_INSERT);
    ev      = do_ins && full;
    sor_d   = sor_q;
    cnt_d   = cnt_q;
    spare_d = spare_q;
    ci_d    = ci_q;
    if (acc) begin
      ci_d = req_i.name_last ? '0 : ci_next;
    end
    if (do_upd) begin
      for (int r = 1; r < CACHE_ENTRIES; r++) begin
        if (RankW'(r) <= hit_rank) sor_d[r] = sor_q[r-1];
      end
      sor_d[0] = hit_slot;
    end else if (do_ins) begin
      for (int r = 1; r < CACHE_ENTRIES; r++) begin
        sor_d[r] = sor_q[r-1];
      end
      sor_d[0] = spare_q;
      cnt_d    = cnt_ins;
      spare_d  = full ? sor_q[CACHE_ENTRIES-1] : free_slot;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < CACHE_ENTRIES; r++) sor_q[r] <= '0;
      cnt_q       <= '0;
      ci_q        <= '0;
      match_q     <= '1;
      spare_q     <= SlotW'(CACHE_ENTRIES);
      out_valid_q <= 1'b0;
    end else begin
      sor_q   <= sor_d;
      cnt_q   <= cnt_d;
      ci_q    <= ci_d;
      spare_q <= spare_d;
      if (acc) begin
        match_q <= req_i.name_last ? '1 : match_d;
      end
      if (acc && req_i.name_last) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Length and address storage, response payload
  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      len_q[spare_q]  <= (ci_next > MaxLen) ? MaxLen[IdxW-1:0] : ci_next[IdxW-1:0];
      addr_q[spare_q] <= req_i.ip_addr;
    end else if (do_upd && req_i.func == FUNC_INSERT) begin
      addr_q[hit_slot] <= req_i.ip_addr;
    end
    if (acc && req_i.name_last) begin
      out_hit_q <= found;
      out_ev_q  <= ev;
      out_ip_q  <= (found && req_i.func == FUNC_QUERY) ? addr_q[hit_slot] : '0;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.hit     = out_hit_q;
  assign rsp_o.ip_out  = out_ip_q;
  assign rsp_o.evicted = out_ev_q;

  `DNSC_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= Full, "entry count above capacity")
  `DNSC_ASSERT(a_spare_bound, clk_i, rst_ni, (SlotW+1)'(spare_q) < (SlotW+1)'(Slots), "spare slot out of range")
  `DNSC_ASSERT(a_last_resp, clk_i, rst_ni, acc && req_i.name_last |=> out_valid_q, "no response after last character")
  `DNSC_ASSERT(a_evict_full, clk_i, rst_ni, ev |-> cnt_q == Full, "eviction below capacity")
  `DNSC_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !out_valid_q, "response valid out of reset")
endmodule
`default_nettype wire

[sim/tb_dns_name_lru_cache.sv]
// Testbench for the DNS name LRU cache: directed table, overlong name, then random name traffic.
`timescale 1ns / 100ps
`default_nettype none
module tb_dns_name_lru_cache;
  import dnsc_pkg::*;

  localparam int unsigned Entries   = 16;
  localparam int unsigned NameBytes = 256;
  localparam int unsigned Slots     = Entries + 1;
  localparam int unsigned MaxStored = NameBytes - 1;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] ip_out;
    logic             evicted;
  } lookup_rsp_t;

  typedef struct {
    func_e            func;
    logic [CharW-1:0] name_char;
    logic             name_last;
    logic [AddrW-1:0] ip_addr;
    logic             has_fixed;
    lookup_rsp_t      fixed_rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  dnsc_req_if req_if ();
  dnsc_rsp_if rsp_if ();

  dns_name_lru_cache #(
    .CACHE_ENTRIES(Entries),
    .NAME_BYTES   (NameBytes)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  // Shadow copy of the cache contents.
  logic [CharW-1:0] shadow_chars [Slots][NameBytes];
  int unsigned      shadow_len   [Slots];
  logic [AddrW-1:0] shadow_addr  [Slots];
  int unsigned      rank_slot    [Entries];
  int unsigned      live_count;
  int unsigned      name_pos;
  bit               still_match  [Entries];
  int unsigned      free_slot;

  lookup_rsp_t expected_rsps[$];
  int          fail_count;
  bit          no_idle;
  bit          long_hold;
  bit          hold_done;
  int unsigned cycle_count;

  // Known names that random traffic reuses, so hits and updates happen.
  logic [CharW-1:0] known_names[$][$];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_progress();
    name_pos = 0;
    for (int r = 0; r < Entries; r++) still_match[r] = 1'b1;
  endfunction

  function automatic void cache_reset();
    for (int r = 0; r < Entries; r++) rank_slot[r] = 0;
    live_count = 0;
    free_slot  = Entries;
    clear_progress();
  endfunction

  // Advance the shadow by one request; return 1 with the response on a last character.
  function automatic bit predict_lookup(input func_e f, input logic [CharW-1:0] ch,
                                        input logic lst, input logic [AddrW-1:0] ip,
                                        output lookup_rsp_t rsp);
    int unsigned s, hit_rank, new_slot, next_free, len;
    bit found, used;
    rsp = '0;
    if (name_pos < MaxStored) begin
      shadow_chars[free_slot][name_pos] = ch;
      for (int r = 0; r < live_count; r++) begin
        s = rank_slot[r];
        if (name_pos >= shadow_len[s] || shadow_chars[s][name_pos] != ch)
          still_match[r] = 1'b0;
      end
      name_pos++;
    end else begin
      for (int r = 0; r < Entries; r++) still_match[r] = 1'b0;
      name_pos = NameBytes;
    end
    if (!lst) return 1'b0;
    len = name_pos;
    found = 1'b0;
    hit_rank = 0;
    for (int r = 0; r < live_count; r++) begin
      if (still_match[r] && shadow_len[rank_slot[r]] == len) begin
        found = 1'b1;
        hit_rank = r;
        break;
      end
    end
    if (found) begin
      s = rank_slot[hit_rank];
      for (int r = hit_rank; r > 0; r--) rank_slot[r] = rank_slot[r-1];
      rank_slot[0] = s;
      rsp.hit = 1'b1;
      if (f == FUNC_QUERY) rsp.ip_out = shadow_addr[s];
      else shadow_addr[s] = ip;
    end else if (f == FUNC_INSERT) begin
      new_slot  = free_slot;
      next_free = Slots;
      if (live_count >= Entries) begin
        next_free   = rank_slot[Entries-1];
        live_count  = Entries - 1;
        rsp.evicted = 1'b1;
      end
      shadow_len[new_slot]  = (len > MaxStored) ? MaxStored : len;
      shadow_addr[new_slot] = ip;
      for (int r = live_count; r > 0; r--) rank_slot[r] = rank_slot[r-1];
      rank_slot[0] = new_slot;
      live_count++;
      if (next_free >= Slots) begin
        for (int sl = 0; sl < Slots && next_free >= Slots; sl++) begin
          used = 1'b0;
          for (int r = 0; r < live_count; r++) if (rank_slot[r] == sl) used = 1'b1;
          if (!used) next_free = sl;
        end
        if (next_free >= Slots) next_free = 0;
      end
      free_slot = next_free;
    end
    clear_progress();
    return 1'b1;
  endfunction

  // Drive one request and hold it until accepted.
  task automatic send_request(input func_e f, input logic [CharW-1:0] ch, input logic lst,
                              input logic [AddrW-1:0] ip, input bit fixed,
                              input lookup_rsp_t fixed_rsp);
    lookup_rsp_t rsp;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.func      <= f;
    req_if.name_char <= ch;
    req_if.name_last <= lst;
    req_if.ip_addr   <= ip;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (predict_lookup(f, ch, lst, ip, rsp)) begin
      if (fixed && rsp != fixed_rsp)
        $display("%0t: table row disagrees with predictor: %p vs %p", $time, fixed_rsp, rsp);
      expected_rsps.push_back(fixed ? fixed_rsp : rsp);
    end
    @(negedge clk_i);
  endtask

  // Send a whole name; junk func and ip on the leading characters.
  task automatic send_name(input func_e f, input logic [CharW-1:0] nm[$],
                           input logic [AddrW-1:0] ip);
    for (int i = 0; i < nm.size(); i++) begin
      if (i == nm.size() - 1) send_request(f, nm[i], 1'b1, ip, 1'b0, '0);
      else send_request(func_e'($urandom_range(0, 1)), nm[i], 1'b0, $urandom, 1'b0, '0);
    end
  endtask

  // Drop valid and wait for every outstanding response.
  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off.
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (60) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if (!no_idle && $urandom_range(0, 5) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare each response with the oldest expectation.
  always @(posedge clk_i) begin
    lookup_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response hit=%0b ip=%h ev=%0b", $time,
                 rsp_if.hit, rsp_if.ip_out, rsp_if.evicted);
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_if.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_if.hit);
          fail_count++;
        end
        if (rsp_if.ip_out !== want.ip_out) begin
          $display("%0t: ip_out expected %h actual %h", $time, want.ip_out, rsp_if.ip_out);
          fail_count++;
        end
        if (rsp_if.evicted !== want.evicted) begin
          $display("%0t: evicted expected %0b actual %0b", $time, want.evicted,
                   rsp_if.evicted);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("dns_name_lru_cache test failed");
      $finish;
    end
  end

  function automatic void random_name(output logic [CharW-1:0] nm[$]);
    int unsigned n;
    nm = {};
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 8);
    for (int i = 0; i < n; i++)
      nm.push_back(($urandom_range(0, 1) == 0) ? CharW'($urandom_range(97, 100)) : CharW'($urandom));
  endfunction

  initial begin
    dir_row_t table_rows[$];
    dir_row_t row;
    logic [CharW-1:0] nm[$];
    logic [CharW-1:0] nm2[$];
    int unsigned pick, items;
    fail_count = 0;
    no_idle = 1'b0;
    long_hold = 1'b0;
    hold_done = 1'b0;
    cycle_count = 0;
    req_if.valid = 1'b0;
    req_if.func = FUNC_QUERY;
    req_if.name_char = '0;
    req_if.name_last = 1'b0;
    req_if.ip_addr = '0;
    rst_ni = 1'b0;
    cache_reset();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed rows: empty query, extreme chars and addresses, insert hit, updates.
    table_rows = '{
      '{FUNC_QUERY,  8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
      '{FUNC_INSERT, 8'h00, 1'b1, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0, 1'b0}},
      '{FUNC_QUERY,  8'h00, 1'b1, 32'h0,         1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
      '{FUNC_INSERT, 8'hFF, 1'b0, 32'h1234_5678, 1'b0, '{1'b0, 32'h0, 1'b0}},
      '{FUNC_INSERT, 8'hFF, 1'b1, 32'h0,         1'b1, '{1'b0, 32'h0, 1'b0}},
      '{FUNC_QUERY,  8'hFF, 1'b1, 32'h0,         1'b1, '{1'b0, 32'h0, 1'b0}},
      '{FUNC_INSERT, 8'hFF, 1'b0, 32'h0,         1'b0, '{1'b0, 32'h0, 1'b0}},
      '{FUNC_INSERT, 8'hFF, 1'b1, 32'hA5A5_5A5A, 1'b1, '{1'b1, 32'h0, 1'b0}},
      '{FUNC_QUERY,  8'hFF, 1'b0, 32'h0,         1'b0, '{1'b0, 32'h0, 1'b0}},
      '{FUNC_QUERY,  8'hFF, 1'b1, 32'h0,         1'b1, '{1'b1, 32'hA5A5_5A5A, 1'b0}},
      '{FUNC_QUERY,  8'hFF, 1'b0, 32'h0,         1'b0, '{1'b0, 32'h0, 1'b0}},
      '{FUNC_QUERY,  8'h00, 1'b1, 32'h0,         1'b0, '{1'b0, 32'h0, 1'b0}},
      '{FUNC_INSERT, 8'h00, 1'b1, 32'h5A5A_A5A5, 1'b1, '{1'b1, 32'h0, 1'b0}},
      '{FUNC_QUERY,  8'h00, 1'b1, 32'h0,         1'b1, '{1'b1, 32'h5A5A_A5A5, 1'b0}}
    };
    foreach (table_rows[i]) begin
      row = table_rows[i];
      send_request(row.func, row.name_char, row.name_last, row.ip_addr, row.has_fixed,
                   row.fixed_rsp);
    end

    // Overlong name: insert it, query its cut prefix, then insert it again.
    nm = {};
    for (int i = 0; i < NameBytes; i++) nm.push_back(CharW'($urandom));
    send_name(FUNC_INSERT, nm, $urandom);
    nm2 = nm[0:MaxStored-1];
    send_name(FUNC_QUERY, nm2, 0);
    send_name(FUNC_INSERT, nm, $urandom);
    drain();
    // Sender pause: let everything arrive before the random part.

    items = 0;
    while (items < 450) begin
      if (items >= 100 && !hold_done) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if (items >= 380) no_idle = 1'b1;
      if (known_names.size() != 0 && $urandom_range(0, 1) != 0) begin
        pick = $urandom_range(0, known_names.size() - 1);
        nm = known_names[pick];
      end else begin
        random_name(nm);
        if (known_names.size() < 40) known_names.push_back(nm);
        else known_names[$urandom_range(0, 39)] = nm;
      end
      if ($urandom_range(0, 15) == 0) begin
        // Abandoned prefix merged into a longer name.
        random_name(nm2);
        nm = {nm2, nm};
      end
      send_name(func_e'($urandom_range(0, 1)), nm, $urandom);
      items += nm.size();
    end

    req_if.valid <= 1'b0;
    drain();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("dns_name_lru_cache test passed");
    end else begin
      $display("dns_name_lru_cache test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/dnsc_pkg.sv
rtl/dnsc_if.sv
rtl/dns_name_lru_cache.sv
sim/tb_dns_name_lru_cache.sv
